FILE: hdl/apvg_pkg.sv
`default_nettype none

package apvg_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;
    localparam int IN_W                = 16;
    localparam int REG_W               = 15;
    localparam int CFG_INDEX_W         = 2;
    localparam int VIDX_W              = 3;
    localparam int NUM_VERTS           = 7;

    localparam logic [VIDX_W-1:0] LAST_VERTEX = 3'd6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_WIDTH  = 2'd0,
        REG_HEAD_HEIGHT = 2'd1,
        REG_HEAD_WIDTH  = 2'd2
    } apvg_reg_t;

    // 2.0 px, 10.0 px and 6.0 px in unsigned q11.4
    localparam logic [REG_W-1:0] LINE_WIDTH_RST  = 15'd32;
    localparam logic [REG_W-1:0] HEAD_HEIGHT_RST = 15'd160;
    localparam logic [REG_W-1:0] HEAD_WIDTH_RST  = 15'd96;

    // per-arrow context carried down the pipeline
    typedef struct packed {
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] offx;
        logic signed [16:0] offy;
        logic signed [17:0] bx;
        logic signed [17:0] by;
        logic signed [17:0] ex;
        logic signed [17:0] ey;
        logic signed [16:0] ox;
        logic signed [16:0] oy;
        logic               neg_x;
        logic               degen;
        logic               zero_den;
    } apvg_ctx_t;

endpackage

`default_nettype wire

FILE: hdl/apvg_arrow_if.sv
`default_nettype none

interface apvg_arrow_if;
    logic                                valid;
    logic                                ready;
    logic signed [apvg_pkg::IN_W-1:0]    start_x;
    logic signed [apvg_pkg::IN_W-1:0]    start_y;
    logic signed [apvg_pkg::IN_W-1:0]    end_x;
    logic signed [apvg_pkg::IN_W-1:0]    end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

FILE: hdl/apvg_vertex_if.sv
`default_nettype none

interface apvg_vertex_if #(
    parameter int COORD_WIDTH = apvg_pkg::COORD_WIDTH_DEFAULT
);
    logic                              valid;
    logic                              ready;
    logic [apvg_pkg::VIDX_W-1:0]       vertex_index;
    logic signed [COORD_WIDTH-1:0]     vertex_x;
    logic signed [COORD_WIDTH-1:0]     vertex_y;
    logic                              last;
    logic                              degenerate;

    modport source (output valid, vertex_index, vertex_x, vertex_y, last, degenerate,
                    input ready);
    modport sink   (input valid, vertex_index, vertex_x, vertex_y, last, degenerate,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/apvg_cfg_if.sv
`default_nettype none

interface apvg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [apvg_pkg::CFG_INDEX_W-1:0]    index;
    logic [apvg_pkg::REG_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/apvg_sqrt.sv
`default_nettype none

// pipelined integer square root, one root bit per stage
module apvg_sqrt #(
    parameter int IN_W   = 34,
    parameter int SIDE_W = 1
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     en,
    input  wire                     in_valid,
    input  wire [IN_W-1:0]          radicand,
    input  wire [SIDE_W-1:0]        side_in,
    output logic                    out_valid,
    output logic [IN_W/2-1:0]       root,
    output logic [SIDE_W-1:0]       side_out
);
    localparam int R_W = IN_W / 2;

    logic [IN_W-1:0]   n_reg    [R_W+1];
    logic [R_W:0]      rem_reg  [R_W+1];
    logic [R_W-1:0]    root_reg [R_W+1];
    logic [SIDE_W-1:0] side_reg [R_W+1];
    logic [R_W:0]      vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[R_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]    <= radicand;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= R_W; k++)
    begin : g_step
        logic [R_W+2:0] part;
        logic [R_W+2:0] trial;
        logic [R_W+2:0] diff;
        logic           ge;
        logic [R_W:0]   rem_next;
        logic [R_W-1:0] root_next;

        always_comb
        begin
            part      = {rem_reg[k-1], n_reg[k-1][IN_W-1:IN_W-2]};
            trial     = {1'b0, root_reg[k-1], 2'b01};
            diff      = part - trial;
            ge        = part >= trial;
            rem_next  = ge ? diff[R_W:0] : part[R_W:0];
            root_next = {root_reg[k-1][R_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= {n_reg[k-1][IN_W-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[R_W];
    assign root      = root_reg[R_W];
    assign side_out  = side_reg[R_W];

endmodule

`default_nettype wire

FILE: hdl/apvg_div.sv
`default_nettype none

// pipelined rounded divide: (num + den/2) / den, one quotient bit per stage
// quotient must fit in Q_W bits
module apvg_div #(
    parameter int NUM_W  = 31,
    parameter int DEN_W  = 17,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     en,
    input  wire                     in_valid,
    input  wire [NUM_W-1:0]         num,
    input  wire [DEN_W-1:0]         den,
    input  wire [SIDE_W-1:0]        side_in,
    output logic                    out_valid,
    output logic [Q_W-1:0]          quot,
    output logic [SIDE_W-1:0]       side_out
);
    localparam int W = DEN_W + Q_W;

    logic [W-1:0]      acc_reg  [Q_W+1];
    logic [DEN_W-1:0]  den_reg  [Q_W+1];
    logic [SIDE_W-1:0] side_reg [Q_W+1];
    logic [Q_W:0]      vld_reg;
    logic [W-1:0]      acc_next;

    assign acc_next = W'(num) + W'(den >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Q_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[0]  <= acc_next;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= Q_W; k++)
    begin : g_step
        logic [DEN_W:0] part;
        logic [DEN_W:0] diff;
        logic           ge;
        logic [W-1:0]   step_next;

        always_comb
        begin
            part      = acc_reg[k-1][W-1:Q_W-1];
            diff      = part - {1'b0, den_reg[k-1]};
            ge        = part >= {1'b0, den_reg[k-1]};
            step_next = ge ? {diff[DEN_W-1:0], acc_reg[k-1][Q_W-2:0], 1'b1}
                           : {part[DEN_W-1:0], acc_reg[k-1][Q_W-2:0], 1'b0};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k]  <= step_next;
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign quot      = acc_reg[Q_W][Q_W-1:0];
    assign side_out  = side_reg[Q_W];

endmodule

`default_nettype wire

FILE: hdl/arrow_polygon_vertex_generator_core.sv
`default_nettype none

// Arrow polygon vertex generator. Each arrow word (tail start_x/start_y, tip
// end_x/end_y, signed q12.4) yields seven vertex words in drawing order: head
// base corner, tip, other head base corner, shaft corner at the head base, two
// shaft corners at the tail, other shaft corner at the head base; the seventh
// carries last. Coordinates saturate to COORD_WIDTH bits. degenerate is set on
// all seven words when the arrow or the shaft has zero length; those offsets
// are then zero. A zero head_height gives a flat head and is not flagged. The
// geometry runs in a fully pipelined datapath (two square roots and six rounded
// divides, one result bit per stage) that takes an arrow in any cycle in which
// the serializer does not stall it; the output serializer drives the seven
// vertex words from a register bank, so the sustained rate is bound by the
// single vertex channel. line_width, head_height and head_width are written
// through cfg (index 0, 1, 2) and must only change while no arrow is in
// flight; cfg is always ready.
module arrow_polygon_vertex_generator_core #(
    parameter int COORD_WIDTH = apvg_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    apvg_cfg_if.sink             cfg,
    apvg_arrow_if.sink           arrow_in,
    apvg_vertex_if.source        vertex_out
);
    localparam int CTX_W = $bits(apvg_pkg::apvg_ctx_t);

    // ---------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------
    function automatic logic [17:0] mag18(input logic signed [17:0] v);
        mag18 = v[17] ? 18'(-v) : 18'(v);
    endfunction

    // apply sign to a divider quotient, zero when the divisor was zero
    function automatic logic signed [16:0] sign_q(input logic [15:0] q, input logic neg,
                                                  input logic zero);
        logic signed [16:0] m;
        m = signed'({1'b0, q});
        if (zero)
        begin
            sign_q = '0;
        end
        else if (neg)
        begin
            sign_q = -m;
        end
        else
        begin
            sign_q = m;
        end
    endfunction

    function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [19:0] v);
        logic signed [32:0] w;
        logic signed [32:0] hi;
        logic signed [32:0] lo;
        w  = 33'(v);
        hi = (33'sd1 <<< (COORD_WIDTH - 1)) - 33'sd1;
        lo = -hi - 33'sd1;
        if (w > hi)
        begin
            sat = hi[COORD_WIDTH-1:0];
        end
        else if (w < lo)
        begin
            sat = lo[COORD_WIDTH-1:0];
        end
        else
        begin
            sat = w[COORD_WIDTH-1:0];
        end
    endfunction

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [apvg_pkg::REG_W-1:0] lw_reg;
    logic [apvg_pkg::REG_W-1:0] hh_reg;
    logic [apvg_pkg::REG_W-1:0] hw_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg <= apvg_pkg::LINE_WIDTH_RST;
            hh_reg <= apvg_pkg::HEAD_HEIGHT_RST;
            hw_reg <= apvg_pkg::HEAD_WIDTH_RST;
        end
        else if (cfg.valid)
        begin
            case (apvg_pkg::apvg_reg_t'(cfg.index))
                apvg_pkg::REG_LINE_WIDTH:  lw_reg <= cfg.data;
                apvg_pkg::REG_HEAD_HEIGHT: hh_reg <= cfg.data;
                apvg_pkg::REG_HEAD_WIDTH:  hw_reg <= cfg.data;
                default:                   ;
            endcase
        end
    end

    // global pipeline advance, driven by the serializer
    logic pipe_en;

    // valid bits of the top-level stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;
    logic sa_vld, dax_vld, day_vld, dbx_vld, dby_vld, sb_vld, dcx_vld, dcy_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg  <= arrow_in.valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= sa_vld;
            v5_reg  <= dax_vld & day_vld;
            v6_reg  <= v5_reg;
            v7_reg  <= dbx_vld & dby_vld;
            v8_reg  <= v7_reg;
            v9_reg  <= sb_vld;
            v10_reg <= dcx_vld & dcy_vld;
            v11_reg <= v10_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: capture, tail minus tip
    // ---------------------------------------------------------------
    apvg_pkg::apvg_ctx_t c1_next, c1_reg;

    always_comb
    begin
        c1_next    = '0;
        c1_next.x1 = arrow_in.start_x;
        c1_next.y1 = arrow_in.start_y;
        c1_next.x2 = arrow_in.end_x;
        c1_next.y2 = arrow_in.end_y;
        c1_next.dx = 17'(arrow_in.start_x) - 17'(arrow_in.end_x);
        c1_next.dy = 17'(arrow_in.start_y) - 17'(arrow_in.end_y);
    end

    // ---------------------------------------------------------------
    // stage 2: squares of the arrow vector
    // ---------------------------------------------------------------
    apvg_pkg::apvg_ctx_t c2_reg;
    logic [17:0] m2x, m2y;
    logic [31:0] sq2x_next, sq2y_next, sq2x_reg, sq2y_reg;

    always_comb
    begin
        m2x       = mag18(18'(c1_reg.dx));
        m2y       = mag18(18'(c1_reg.dy));
        sq2x_next = m2x[15:0] * m2x[15:0];
        sq2y_next = m2y[15:0] * m2y[15:0];
    end

    // ---------------------------------------------------------------
    // stage 3: squared length
    // ---------------------------------------------------------------
    apvg_pkg::apvg_ctx_t c3_reg;
    logic [33:0] sum3_next, sum3_reg;

    assign sum3_next = 34'(sq2x_reg) + 34'(sq2y_reg);

    // arrow length d
    apvg_pkg::apvg_ctx_t sa_ctx;
    logic [16:0] sa_root;

    apvg_sqrt #(
        .IN_W   (34),
        .SIDE_W (CTX_W)
    ) u_sqrt_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v3_reg),
        .radicand  (sum3_reg),
        .side_in   (c3_reg),
        .out_valid (sa_vld),
        .root      (sa_root),
        .side_out  (sa_ctx)
    );

    // ---------------------------------------------------------------
    // stage 4: head base numerators, ddx * head_height
    // ---------------------------------------------------------------
    apvg_pkg::apvg_ctx_t c4_next, c4_reg;
    logic [17:0] m4x, m4y;
    logic [30:0] n4x_next, n4y_next, n4x_reg, n4y_reg;
    logic        neg4y_next, neg4y_reg;
    logic [16:0] d4_reg;

    always_comb
    begin
        c4_next          = sa_ctx;
        c4_next.degen    = sa_root == '0;
        c4_next.zero_den = sa_root == '0;
        c4_next.neg_x    = sa_ctx.dx[16];
        neg4y_next       = sa_ctx.dy[16];
        m4x              = mag18(18'(sa_ctx.dx));
        m4y              = mag18(18'(sa_ctx.dy));
        n4x_next         = m4x[15:0] * hh_reg;
        n4y_next         = m4y[15:0] * hh_reg;
    end

    apvg_pkg::apvg_ctx_t da_ctx;
    logic [15:0] dax_q, day_q;
    logic        day_neg;

    apvg_div #(
        .NUM_W  (31),
        .DEN_W  (17),
        .Q_W    (16),
        .SIDE_W (CTX_W)
    ) u_div_base_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v4_reg),
        .num       (n4x_reg),
        .den       (d4_reg),
        .side_in   (c4_reg),
        .out_valid (dax_vld),
        .quot      (dax_q),
        .side_out  (da_ctx)
    );

    apvg_div #(
        .NUM_W  (31),
        .DEN_W  (17),
        .Q_W    (16),
        .SIDE_W (1)
    ) u_div_base_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v4_reg),
        .num       (n4y_reg),
        .den       (d4_reg),
        .side_in   (neg4y_reg),
        .out_valid (day_vld),
        .quot      (day_q),
        .side_out  (day_neg)
    );

    // ---------------------------------------------------------------
    // stage 5: head base point B
    // ---------------------------------------------------------------
    apvg_pkg::apvg_ctx_t c5_next, c5_reg;

    always_comb
    begin
        c5_next      = da_ctx;
        c5_next.offx = sign_q(dax_q, da_ctx.neg_x, da_ctx.zero_den);
        c5_next.offy = sign_q(day_q, day_neg, da_ctx.zero_den);
        c5_next.bx   = 18'(da_ctx.x2) + 18'(c5_next.offx);
        c5_next.by   = 18'(da_ctx.y2) + 18'(c5_next.offy);
    end

    // ---------------------------------------------------------------
    // stage 6: head offset numerators, shaft vector
    // ---------------------------------------------------------------
    apvg_pkg::apvg_ctx_t c6_next, c6_reg;
    logic [17:0] m6x, m6y;
    logic [30:0] n6x_next, n6y_next, n6x_reg, n6y_reg;
    logic        neg6y_next, neg6y_reg;

    always_comb
    begin
        c6_next          = c5_reg;
        c6_next.ex       = c5_reg.bx - 18'(c5_reg.x1);
        c6_next.ey       = c5_reg.by - 18'(c5_reg.y1);
        c6_next.zero_den = hh_reg == '0;
        // ox follows the y offset, oy the negated x offset
        c6_next.neg_x    = c5_reg.offy[16];
        neg6y_next       = !c5_reg.offx[16] && (c5_reg.offx != '0);
        m6x              = mag18(18'(c5_reg.offy));
        m6y              = mag18(18'(c5_reg.offx));
        n6x_next         = m6x[15:0] * hw_reg;
        n6y_next         = m6y[15:0] * hw_reg;
    end

    apvg_pkg::apvg_ctx_t db_ctx;
    logic [15:0] dbx_q, dby_q;
    logic        dby_neg;

    apvg_div #(
        .NUM_W  (31),
        .DEN_W  (apvg_pkg::REG_W),
        .Q_W    (16),
        .SIDE_W (CTX_W)
    ) u_div_head_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v6_reg),
        .num       (n6x_reg),
        .den       (hh_reg),
        .side_in   (c6_reg),
        .out_valid (dbx_vld),
        .quot      (dbx_q),
        .side_out  (db_ctx)
    );

    apvg_div #(
        .NUM_W  (31),
        .DEN_W  (apvg_pkg::REG_W),
        .Q_W    (16),
        .SIDE_W (1)
    ) u_div_head_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v6_reg),
        .num       (n6y_reg),
        .den       (hh_reg),
        .side_in   (neg6y_reg),
        .out_valid (dby_vld),
        .quot      (dby_q),
        .side_out  (dby_neg)
    );

    // ---------------------------------------------------------------
    // stage 7: head offsets, squares of the shaft vector
    // ---------------------------------------------------------------
    apvg_pkg::apvg_ctx_t c7_next, c7_reg;
    logic [17:0] m7x, m7y;
    logic [33:0] sq7x_next, sq7y_next, sq7x_reg, sq7y_reg;

    always_comb
    begin
        c7_next    = db_ctx;
        c7_next.ox = sign_q(dbx_q, db_ctx.neg_x, db_ctx.zero_den);
        c7_next.oy = sign_q(dby_q, dby_neg, db_ctx.zero_den);
        m7x        = mag18(db_ctx.ex);
        m7y        = mag18(db_ctx.ey);
        sq7x_next  = m7x[16:0] * m7x[16:0];
        sq7y_next  = m7y[16:0] * m7y[16:0];
    end

    // ---------------------------------------------------------------
    // stage 8: squared shaft length
    // ---------------------------------------------------------------
    apvg_pkg::apvg_ctx_t c8_reg;
    logic [35:0] sum8_next, sum8_reg;

    assign sum8_next = 36'(sq7x_reg) + 36'(sq7y_reg);

    apvg_pkg::apvg_ctx_t sb_ctx;
    logic [17:0] sb_root;

    apvg_sqrt #(
        .IN_W   (36),
        .SIDE_W (CTX_W)
    ) u_sqrt_shaft (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v8_reg),
        .radicand  (sum8_reg),
        .side_in   (c8_reg),
        .out_valid (sb_vld),
        .root      (sb_root),
        .side_out  (sb_ctx)
    );

    // ---------------------------------------------------------------
    // stage 9: shaft offset numerators
    // ---------------------------------------------------------------
    apvg_pkg::apvg_ctx_t c9_next, c9_reg;
    logic [17:0] m9x, m9y;
    logic [31:0] n9x_next, n9y_next, n9x_reg, n9y_reg;
    logic        neg9y_next, neg9y_reg;
    logic [17:0] d9_reg;

    always_comb
    begin
        c9_next          = sb_ctx;
        c9_next.zero_den = sb_root == '0;
        c9_next.degen    = sb_ctx.degen || (sb_root == '0);
        // sx from start_y - by, sy from bx - start_x
        c9_next.neg_x    = !sb_ctx.ey[17] && (sb_ctx.ey != '0);
        neg9y_next       = sb_ctx.ex[17];
        m9x              = mag18(sb_ctx.ey);
        m9y              = mag18(sb_ctx.ex);
        n9x_next         = m9x[16:0] * lw_reg;
        n9y_next         = m9y[16:0] * lw_reg;
    end

    apvg_pkg::apvg_ctx_t dc_ctx;
    logic [15:0] dcx_q, dcy_q;
    logic        dcy_neg;

    apvg_div #(
        .NUM_W  (32),
        .DEN_W  (18),
        .Q_W    (16),
        .SIDE_W (CTX_W)
    ) u_div_shaft_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v9_reg),
        .num       (n9x_reg),
        .den       (d9_reg),
        .side_in   (c9_reg),
        .out_valid (dcx_vld),
        .quot      (dcx_q),
        .side_out  (dc_ctx)
    );

    apvg_div #(
        .NUM_W  (32),
        .DEN_W  (18),
        .Q_W    (16),
        .SIDE_W (1)
    ) u_div_shaft_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v9_reg),
        .num       (n9y_reg),
        .den       (d9_reg),
        .side_in   (neg9y_reg),
        .out_valid (dcy_vld),
        .quot      (dcy_q),
        .side_out  (dcy_neg)
    );

    // ---------------------------------------------------------------
    // stage 10: shaft offsets
    // ---------------------------------------------------------------
    apvg_pkg::apvg_ctx_t c10_reg;
    logic signed [16:0] sx10_next, sy10_next, sx10_reg, sy10_reg;

    assign sx10_next = sign_q(dcx_q, dc_ctx.neg_x, dc_ctx.zero_den);
    assign sy10_next = sign_q(dcy_q, dcy_neg, dc_ctx.zero_den);

    // ---------------------------------------------------------------
    // stage 11: seven vertices, saturated
    // ---------------------------------------------------------------
    logic [COORD_WIDTH-1:0] vx11_next [apvg_pkg::NUM_VERTS];
    logic [COORD_WIDTH-1:0] vy11_next [apvg_pkg::NUM_VERTS];
    logic [COORD_WIDTH-1:0] vx11_reg  [apvg_pkg::NUM_VERTS];
    logic [COORD_WIDTH-1:0] vy11_reg  [apvg_pkg::NUM_VERTS];
    logic                   deg11_reg;

    always_comb
    begin
        vx11_next[0] = sat(20'(c10_reg.bx) - 20'(c10_reg.ox));
        vy11_next[0] = sat(20'(c10_reg.by) - 20'(c10_reg.oy));
        vx11_next[1] = sat(20'(c10_reg.x2));
        vy11_next[1] = sat(20'(c10_reg.y2));
        vx11_next[2] = sat(20'(c10_reg.bx) + 20'(c10_reg.ox));
        vy11_next[2] = sat(20'(c10_reg.by) + 20'(c10_reg.oy));
        vx11_next[3] = sat(20'(c10_reg.bx) + 20'(sx10_reg));
        vy11_next[3] = sat(20'(c10_reg.by) + 20'(sy10_reg));
        vx11_next[4] = sat(20'(c10_reg.x1) + 20'(sx10_reg));
        vy11_next[4] = sat(20'(c10_reg.y1) + 20'(sy10_reg));
        vx11_next[5] = sat(20'(c10_reg.x1) - 20'(sx10_reg));
        vy11_next[5] = sat(20'(c10_reg.y1) - 20'(sy10_reg));
        vx11_next[6] = sat(20'(c10_reg.bx) - 20'(sx10_reg));
        vy11_next[6] = sat(20'(c10_reg.by) - 20'(sy10_reg));
    end

    // datapath payload registers, all held on stall
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            c1_reg    <= c1_next;
            c2_reg    <= c1_reg;
            sq2x_reg  <= sq2x_next;
            sq2y_reg  <= sq2y_next;
            c3_reg    <= c2_reg;
            sum3_reg  <= sum3_next;
            c4_reg    <= c4_next;
            n4x_reg   <= n4x_next;
            n4y_reg   <= n4y_next;
            neg4y_reg <= neg4y_next;
            d4_reg    <= sa_root;
            c5_reg    <= c5_next;
            c6_reg    <= c6_next;
            n6x_reg   <= n6x_next;
            n6y_reg   <= n6y_next;
            neg6y_reg <= neg6y_next;
            c7_reg    <= c7_next;
            sq7x_reg  <= sq7x_next;
            sq7y_reg  <= sq7y_next;
            c8_reg    <= c7_reg;
            sum8_reg  <= sum8_next;
            c9_reg    <= c9_next;
            n9x_reg   <= n9x_next;
            n9y_reg   <= n9y_next;
            neg9y_reg <= neg9y_next;
            d9_reg    <= sb_root;
            c10_reg   <= dc_ctx;
            sx10_reg  <= sx10_next;
            sy10_reg  <= sy10_next;
            vx11_reg  <= vx11_next;
            vy11_reg  <= vy11_next;
            deg11_reg <= c10_reg.degen;
        end
    end

    // ---------------------------------------------------------------
    // output serializer: one vertex word per handshake
    // ---------------------------------------------------------------
    logic [COORD_WIDTH-1:0]        vx_reg [apvg_pkg::NUM_VERTS];
    logic [COORD_WIDTH-1:0]        vy_reg [apvg_pkg::NUM_VERTS];
    logic                          deg_reg;
    logic [apvg_pkg::VIDX_W-1:0]   idx_reg, idx_next;
    logic                          busy_reg, busy_next;
    logic                          take, last_take, load;

    assign take      = busy_reg && vertex_out.ready;
    assign last_take = take && (idx_reg == apvg_pkg::LAST_VERTEX);
    // the bank frees up as its last word leaves, so a new arrow loads with no gap
    assign pipe_en   = !v11_reg || !busy_reg || last_take;
    assign load      = v11_reg && pipe_en;

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (last_take)
        begin
            busy_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vx_reg  <= vx11_reg;
            vy_reg  <= vy11_reg;
            deg_reg <= deg11_reg;
        end
    end

    assign arrow_in.ready          = pipe_en;
    assign vertex_out.valid        = busy_reg;
    assign vertex_out.vertex_index = idx_reg;
    assign vertex_out.vertex_x     = vx_reg[idx_reg];
    assign vertex_out.vertex_y     = vy_reg[idx_reg];
    assign vertex_out.last         = idx_reg == apvg_pkg::LAST_VERTEX;
    assign vertex_out.degenerate   = deg_reg;

endmodule

`default_nettype wire

FILE: hdl/apvg_checker.sv
`default_nettype none

module apvg_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            out_valid,
    input wire                            out_ready,
    input wire [apvg_pkg::VIDX_W-1:0]     vertex_index,
    input wire                            last,
    input wire                            degenerate
);

    // stalled word keeps its vertex index and degenerate flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vertex_index)
                                    && $stable(degenerate))
        else $error("vertex word changed under stall");

    // last marks exactly the seventh vertex
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (vertex_index == apvg_pkg::LAST_VERTEX)))
        else $error("last does not match vertex index");

    // vertices of one arrow follow without gaps, in order
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last
        |=> out_valid && (vertex_index == $past(vertex_index) + 3'd1))
        else $error("vertex sequence broken");

    // degenerate is one value across an arrow
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> degenerate == $past(degenerate))
        else $error("degenerate changed within an arrow");

endmodule

bind arrow_polygon_vertex_generator_core apvg_checker u_apvg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (vertex_out.valid),
    .out_ready    (vertex_out.ready),
    .vertex_index (vertex_out.vertex_index),
    .last         (vertex_out.last),
    .degenerate   (vertex_out.degenerate)
);

`default_nettype wire
